/* design/wdw_pkg.sv */
// Shared constants, codes and types of the weighted draw block.
`default_nettype none

package wdw_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int RND_W     = 32;
    localparam int ID_W      = 32;
    localparam int ROT_W     = 32;
    localparam int CAT_W     = 3;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 3;
    localparam int IN_WT_W   = 16;
    localparam int OUT_IDX_W = 6;
    localparam int PICK_W    = 7;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic [PICK_W-1:0] MAX_PICKS_RST = 7'd8;

    localparam logic REG_MAX_PICKS = 1'b0;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd3;

    localparam logic [STAT_W-1:0] ST_PICKED = 3'd0;
    localparam logic [STAT_W-1:0] ST_ACK    = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_LIMIT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SWEEP,
        S_WALK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/weighted_draw_without_replacement.sv */
// Top level: weighted draw without replacement over a loaded entry table.
//
//  Channel   Direction  Handshake              Contents
//  input     in         in_valid / in_stall    command and entry, rotation, random fields
//  output    out        out_valid / out_stall  status, picked entry, rotation tag, last
//  config    in         APB write/read         max_picks at address 0
//
// Load, clear and refused draws pass from acceptance through the result registers and S_DONE to the output register.
// Start rotation sweeps the table, one table read per cycle, to set the availability flags and remaining sum.
// A draw runs the serial modulo unit, then walks the table until the running sum of available weights reaches the roll.
// Reset clears the control registers, counters and remaining sum; the table itself is not cleared and needs no sweep.
// A result held by out_stall keeps the next result waiting in S_DONE, so the input stalls until the held one is taken.
`default_nettype none

module weighted_draw_without_replacement #(
    parameter int MAX_ENTRIES = wdw_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = wdw_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [wdw_pkg::CMD_W-1:0]      command,
    input  logic [wdw_pkg::ID_W-1:0]       item_id,
    input  logic [wdw_pkg::IN_WT_W-1:0]    weight,
    input  logic [wdw_pkg::CAT_W-1:0]      category,
    input  logic                           enabled,
    input  logic [wdw_pkg::ROT_W-1:0]      rotation_id,
    input  logic [wdw_pkg::RND_W-1:0]      random_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [wdw_pkg::STAT_W-1:0]     status,
    output logic [wdw_pkg::ID_W-1:0]       picked_item,
    output logic [wdw_pkg::CAT_W-1:0]      picked_category,
    output logic [wdw_pkg::OUT_IDX_W-1:0]  picked_index,
    output logic [wdw_pkg::ROT_W-1:0]      rotation_tag,
    output logic                           last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wdw_pkg::ADDR_W-1:0]     paddr,
    input  logic [wdw_pkg::DATA_W-1:0]     pwdata,
    output logic [wdw_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import wdw_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int WB    = WEIGHT_BITS;
    localparam int RW    = WB + IDX_W;
    localparam int ENT_W = ID_W + WB + CAT_W + 1;

    logic [ENT_W-1:0] entry_mem [MAX_ENTRIES];
    logic             avail_mem [MAX_ENTRIES];

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [PICK_W-1:0] picks_reg, picks_next;
    logic [ROT_W-1:0]  rot_reg, rot_next;
    logic [PICK_W-1:0] max_picks_reg, max_picks_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              pend_reg;
    logic              out_valid_reg, out_valid_next;

    logic [RW-1:0]     cum_reg, cum_next;
    logic [RW-1:0]     roll_reg, roll_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_item_reg, res_item_next;
    logic [CAT_W-1:0]  res_cat_reg, res_cat_next;
    logic [OUT_IDX_W-1:0] res_idx_reg, res_idx_next;

    logic [ENT_W-1:0]  rd_ent_reg;
    logic              rd_av_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    logic [STAT_W-1:0]    out_status_reg;
    logic [ID_W-1:0]      out_item_reg;
    logic [CAT_W-1:0]     out_cat_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [ROT_W-1:0]     out_rot_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 full;
    logic                 limit;
    logic                 rem_zero;
    logic                 issue;
    logic                 walk_end;
    logic                 hit;
    logic                 out_free;
    logic                 out_load;
    logic                 cfg_write;
    logic                 ent_we;
    logic                 av_we;
    logic [IDX_W-1:0]     av_waddr;
    logic                 av_wdata;
    logic                 mod_start;
    logic                 mod_done;
    logic [RW-1:0]        mod_rem;
    logic [ENT_W-1:0]     new_entry;
    logic [WB+IN_WT_W-1:0] wt_ext;
    logic [ID_W-1:0]      ent_id;
    logic [WB-1:0]        ent_wt;
    logic [CAT_W-1:0]     ent_cat;
    logic                 ent_en;
    logic [RW:0]          cum_sum;
    logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign limit    = (picks_reg >= max_picks_reg);
    assign rem_zero = (rem_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_DONE) && out_free;

    assign wt_ext    = {{WB{1'b0}}, weight};
    assign new_entry = {item_id, wt_ext[WB-1:0], category, enabled};

    assign ent_id  = rd_ent_reg[ENT_W-1 -: ID_W];
    assign ent_wt  = rd_ent_reg[WB+CAT_W:CAT_W+1];
    assign ent_cat = rd_ent_reg[CAT_W:1];
    assign ent_en  = rd_ent_reg[0];

    assign cum_sum  = {1'b0, cum_reg} + {{(IDX_W+1){1'b0}}, ent_wt};
    assign hit      = (state_reg == S_WALK) && pend_reg && rd_av_reg
                      && (cum_sum >= {1'b0, roll_reg});
    assign walk_end = (addr_reg >= count_reg) && !pend_reg;
    assign issue    = ((state_reg == S_SWEEP) || ((state_reg == S_WALK) && !hit))
                      && (addr_reg < count_reg);
    assign idx_ext  = {{OUT_IDX_W{1'b0}}, rd_idx_reg};

    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_PICKS);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MAX_PICKS)
                       ? {{(DATA_W-PICK_W){1'b0}}, max_picks_reg} : '0;
    assign max_picks_next = cfg_write ? pwdata[PICK_W-1:0] : max_picks_reg;

    wdw_mod_unit #(
        .DIV_W(RW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (random_value),
        .divisor  (rem_reg),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_START: state_next = S_SWEEP;
                        CMD_DRAW:  state_next = (limit || rem_zero) ? S_DONE : S_MOD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_WALK;
                end
            end
            S_SWEEP:
            begin
                if (walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (hit || walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        rem_next        = rem_reg;
        picks_next      = picks_reg;
        rot_next        = rot_reg;
        addr_next       = addr_reg;
        cum_next        = cum_reg;
        roll_next       = roll_reg;
        res_status_next = res_status_reg;
        res_item_next   = res_item_reg;
        res_cat_next    = res_cat_reg;
        res_idx_next    = res_idx_reg;
        ent_we          = 1'b0;
        av_we           = 1'b0;
        av_waddr        = rd_idx_reg;
        av_wdata        = 1'b0;
        mod_start       = 1'b0;
        if (issue)
        begin
            addr_next = addr_reg + CNT_W'(1);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_ACK;
                    res_item_next   = '0;
                    res_cat_next    = '0;
                    res_idx_next    = '0;
                    case (command)
                        CMD_LOAD:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                av_we      = 1'b1;
                                av_waddr   = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            rem_next   = '0;
                        end
                        CMD_START:
                        begin
                            rot_next   = rotation_id;
                            picks_next = '0;
                            rem_next   = '0;
                            addr_next  = '0;
                        end
                        default:
                        begin
                            if (limit)
                            begin
                                res_status_next = ST_LIMIT;
                            end
                            else if (rem_zero)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mod_start = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    roll_next = mod_rem + RW'(1);
                    cum_next  = '0;
                    addr_next = '0;
                end
            end
            S_SWEEP:
            begin
                if (pend_reg)
                begin
                    av_we    = 1'b1;
                    av_wdata = ent_en;
                    if (ent_en)
                    begin
                        rem_next = rem_reg + {{IDX_W{1'b0}}, ent_wt};
                    end
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    av_we           = 1'b1;
                    rem_next        = rem_reg - {{IDX_W{1'b0}}, ent_wt};
                    picks_next      = picks_reg + PICK_W'(1);
                    res_status_next = ST_PICKED;
                    res_item_next   = ent_id;
                    res_cat_next    = ent_cat;
                    res_idx_next    = idx_ext[OUT_IDX_W-1:0];
                end
                else
                begin
                    if (pend_reg && rd_av_reg)
                    begin
                        cum_next = cum_sum[RW-1:0];
                    end
                    if (walk_end)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            picks_reg     <= '0;
            rot_reg       <= '0;
            max_picks_reg <= MAX_PICKS_RST;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            picks_reg     <= picks_next;
            rot_reg       <= rot_next;
            max_picks_reg <= max_picks_next;
            addr_reg      <= addr_next;
            pend_reg      <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cum_reg        <= cum_next;
        roll_reg       <= roll_next;
        res_status_reg <= res_status_next;
        res_item_reg   <= res_item_next;
        res_cat_reg    <= res_cat_next;
        res_idx_reg    <= res_idx_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_item_reg   <= res_item_reg;
            out_cat_reg    <= res_cat_reg;
            out_idx_reg    <= res_idx_reg;
            out_rot_reg    <= rot_reg;
            out_last_reg   <= limit || rem_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_ent_reg <= entry_mem[addr_reg[IDX_W-1:0]];
            rd_av_reg  <= avail_mem[addr_reg[IDX_W-1:0]];
            rd_idx_reg <= addr_reg[IDX_W-1:0];
        end
        if (ent_we)
        begin
            entry_mem[count_reg[IDX_W-1:0]] <= new_entry;
        end
        if (av_we)
        begin
            avail_mem[av_waddr] <= av_wdata;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign picked_item     = out_item_reg;
    assign picked_category = out_cat_reg;
    assign picked_index    = out_idx_reg;
    assign rotation_tag    = out_rot_reg;
    assign last            = out_last_reg;

endmodule

`default_nettype wire

/* design/wdw_mod_unit.sv */
// Bit-serial restoring modulo unit: one dividend bit per cycle.
`default_nettype none

module wdw_mod_unit #(
    parameter int DIV_W = 22
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wdw_pkg::RND_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          remainder
);
    import wdw_pkg::*;

    localparam int CNT_W = $clog2(RND_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RND_W-1:0] dvd_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] rem_step;

    assign trial    = {rem_reg, dvd_reg[RND_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign rem_step = (trial >= {1'b0, divisor}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    assign done      = busy_reg && (cnt_reg == CNT_W'(RND_W - 1));
    assign remainder = rem_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

endmodule

`default_nettype wire

/* design/wdw_checker.sv */
// Port-level checker for the weighted draw block, bound to the top level.
`default_nettype none

module wdw_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [wdw_pkg::STAT_W-1:0]    status,
    input wire logic [wdw_pkg::ID_W-1:0]      picked_item,
    input wire logic [wdw_pkg::CAT_W-1:0]     picked_category,
    input wire logic [wdw_pkg::OUT_IDX_W-1:0] picked_index
);
    import wdw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Output transaction dropped while stalled.");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_FULL)
        else $error("Status code out of range.");

    a_no_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_PICKED) |->
            (picked_item == '0) && (picked_category == '0) && (picked_index == '0))
        else $error("Picked fields not zero on a result without a pick.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Input accepted again without processing the previous transaction.");

endmodule

bind weighted_draw_without_replacement wdw_checker u_wdw_checker (.*);

`default_nettype wire
